FILE: rtl/tea_pkg.sv
// ----------------------------------------------------------------------------
// TEA package
// Shared word, stage and configuration types for the TEA block cipher.
// ----------------------------------------------------------------------------
package tea_pkg;

    localparam int WORD_W    = 32;
    localparam int CFG_IDX_W = 3;
    localparam int SHIFT_L   = 4;
    localparam int SHIFT_R   = 5;

    typedef logic [WORD_W-1:0] word_t;

    localparam word_t DELTA_RESET = 32'h9E37_79B9;

    // Register indexes of the configuration port.
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_KEY_0 = 3'd0,
        CFG_KEY_1 = 3'd1,
        CFG_KEY_2 = 3'd2,
        CFG_KEY_3 = 3'd3,
        CFG_DELTA = 3'd4
    } cfg_idx_t;

    // One block in flight, with its mode and running sum.
    typedef struct packed {
        logic  mode;
        word_t a;
        word_t b;
        word_t sum;
    } stage_t;

    // One finished block waiting at the output.
    typedef struct packed {
        word_t a;
        word_t b;
    } blk_t;

endpackage

FILE: rtl/tea_if.sv
// ----------------------------------------------------------------------------
// TEA channel interfaces
// Valid/ready channels for input blocks and for transformed blocks.
// ----------------------------------------------------------------------------
interface tea_block_if;
    logic                valid;
    logic                ready;
    logic                mode;
    tea_pkg::word_t      half_a_in;
    tea_pkg::word_t      half_b_in;

    modport source (output valid, output mode, output half_a_in, output half_b_in,
                    input ready);
    modport sink   (input valid, input mode, input half_a_in, input half_b_in,
                    output ready);
endinterface

interface tea_result_if;
    logic                valid;
    logic                ready;
    tea_pkg::word_t      half_a_out;
    tea_pkg::word_t      half_b_out;

    modport source (output valid, output half_a_out, output half_b_out, input ready);
    modport sink   (input valid, input half_a_out, input half_b_out, output ready);
endinterface

FILE: rtl/tea_half_round.sv
// ----------------------------------------------------------------------------
// TEA half-round stage
// One registered half of a TEA round, for either direction of the cipher.
// ----------------------------------------------------------------------------
module tea_half_round #(
    parameter bit SECOND = 1'b0
) (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            advance,
    input  logic            valid_in,
    input  tea_pkg::stage_t data_in,
    input  tea_pkg::word_t  key_0,
    input  tea_pkg::word_t  key_1,
    input  tea_pkg::word_t  key_2,
    input  tea_pkg::word_t  key_3,
    input  tea_pkg::word_t  delta,
    output logic            valid_out,
    output tea_pkg::stage_t data_out
);
    import tea_pkg::*;

    logic   valid_reg;
    stage_t data_reg;
    stage_t data_next;
    logic   src_is_b;
    word_t  src;
    word_t  key_lo;
    word_t  key_hi;
    word_t  mix_val;

    // Encryption updates a from b and then b from a; decryption runs the
    // same two updates in the opposite order, so the source half depends on
    // both the mode and which half of the round this stage holds.
    always_comb
    begin
        src_is_b  = (data_in.mode == SECOND);
        data_next = data_in;
        if (src_is_b)
        begin
            src    = data_in.b;
            key_lo = key_0;
            key_hi = key_1;
        end
        else
        begin
            src    = data_in.a;
            key_lo = key_2;
            key_hi = key_3;
        end
        mix_val = ((src << SHIFT_L) + key_lo) ^ (src + data_in.sum) ^
                  ((src >> SHIFT_R) + key_hi);
        if (src_is_b)
        begin
            data_next.a = data_in.mode ? data_in.a - mix_val : data_in.a + mix_val;
        end
        else
        begin
            data_next.b = data_in.mode ? data_in.b - mix_val : data_in.b + mix_val;
        end
        if (SECOND)
        begin
            data_next.sum = data_in.mode ? data_in.sum - delta : data_in.sum + delta;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            valid_reg <= valid_in;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance && valid_in)
        begin
            data_reg <= data_next;
        end
    end

    assign valid_out = valid_reg;
    assign data_out  = data_reg;

endmodule

FILE: rtl/tea_block_cipher.sv
// ----------------------------------------------------------------------------
// TEA block cipher
// Fully pipelined TEA encryption and decryption of 64-bit blocks.
// ----------------------------------------------------------------------------
// Blocks arrive on the block channel as two 32-bit halves and a mode bit
// (0 encrypts, 1 decrypts); transformed blocks leave on the result channel.
// Both channels move one transfer at a clock edge where valid and ready are
// high. Key words and delta are written through the plain write port
// (cfg_we, cfg_index, cfg_data); the user must do so only while no block
// is in flight, as the block does not enforce it. Writes to indexes beyond
// delta are ignored. Each round is split into two half-round stages, so
// the pipeline holds an entry stage and 2*ROUNDS half-round stages, and
// one block is taken every cycle while the receiver keeps up.
// The output register has a one-entry skid stage behind it. When the
// receiver stalls, the pipeline keeps moving until the skid stage is full,
// and a bubble at the last stage still lets the pipeline move; nothing is
// lost or repeated.
// Reset clears every valid bit, loads the key words with zero and delta
// with 0x9E3779B9.
// ----------------------------------------------------------------------------
module tea_block_cipher #(
    parameter int ROUNDS = 32
) (
    input  logic                            clk,
    input  logic                            rst_n,
    tea_block_if.sink                       block,
    tea_result_if.source                    result,
    input  logic                            cfg_we,
    input  logic [tea_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  tea_pkg::word_t                  cfg_data
);
    import tea_pkg::*;

    localparam int    NSTAGES  = 2 * ROUNDS;
    localparam word_t ROUNDS_W = WORD_W'(ROUNDS);

    word_t  key_0_reg;
    word_t  key_1_reg;
    word_t  key_2_reg;
    word_t  key_3_reg;
    word_t  delta_reg;

    logic   [NSTAGES:0] stage_valid;
    stage_t             stage_data [NSTAGES+1];

    logic   entry_valid_reg;
    stage_t entry_data_reg;
    stage_t entry_next;
    word_t  dec_sum;

    logic   advance;
    logic   push;
    logic   pop;
    logic   out_valid_reg;
    logic   out_valid_next;
    logic   skid_valid_reg;
    logic   skid_valid_next;
    logic   out_load;
    logic   out_from_skid;
    logic   skid_load;
    blk_t   out_data_reg;
    blk_t   skid_data_reg;
    blk_t   last_blk;

    // Configuration registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            key_0_reg <= '0;
            key_1_reg <= '0;
            key_2_reg <= '0;
            key_3_reg <= '0;
            delta_reg <= DELTA_RESET;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_KEY_0: key_0_reg <= cfg_data;
                CFG_KEY_1: key_1_reg <= cfg_data;
                CFG_KEY_2: key_2_reg <= cfg_data;
                CFG_KEY_3: key_3_reg <= cfg_data;
                CFG_DELTA: delta_reg <= cfg_data;
                default:   ;
            endcase
        end
    end

    // The pipeline moves as a whole unless the skid stage is full and the
    // last stage holds a block that would have nowhere to go.
    assign advance     = !skid_valid_reg || !stage_valid[NSTAGES];
    assign block.ready = advance;

    // Decryption starts from delta times the round count, modulo 2^32.
    assign dec_sum = delta_reg * ROUNDS_W;

    always_comb
    begin
        entry_next.mode = block.mode;
        entry_next.a    = block.half_a_in;
        entry_next.b    = block.half_b_in;
        entry_next.sum  = block.mode ? dec_sum : delta_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            entry_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            entry_valid_reg <= block.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance && block.valid)
        begin
            entry_data_reg <= entry_next;
        end
    end

    assign stage_valid[0] = entry_valid_reg;
    assign stage_data[0]  = entry_data_reg;

    for (genvar i = 1; i <= NSTAGES; i++)
    begin : g_stage
        tea_half_round #(
            .SECOND (((i - 1) % 2) == 1)
        ) u_half_round (
            .clk       (clk),
            .rst_n     (rst_n),
            .advance   (advance),
            .valid_in  (stage_valid[i-1]),
            .data_in   (stage_data[i-1]),
            .key_0     (key_0_reg),
            .key_1     (key_1_reg),
            .key_2     (key_2_reg),
            .key_3     (key_3_reg),
            .delta     (delta_reg),
            .valid_out (stage_valid[i]),
            .data_out  (stage_data[i])
        );
    end

    assign last_blk.a = stage_data[NSTAGES].a;
    assign last_blk.b = stage_data[NSTAGES].b;

    assign push = advance && stage_valid[NSTAGES];
    assign pop  = out_valid_reg && result.ready;

    // Output register with a skid stage behind it. A push never meets a full
    // skid stage, because the pipeline holds still in that case.
    always_comb
    begin
        out_valid_next  = out_valid_reg;
        skid_valid_next = skid_valid_reg;
        out_load        = 1'b0;
        out_from_skid   = 1'b0;
        skid_load       = 1'b0;
        if (pop)
        begin
            if (skid_valid_reg)
            begin
                out_from_skid   = 1'b1;
                skid_valid_next = 1'b0;
            end
            else
            begin
                out_load       = push;
                out_valid_next = push;
            end
        end
        else if (push)
        begin
            if (out_valid_reg)
            begin
                skid_load       = 1'b1;
                skid_valid_next = 1'b1;
            end
            else
            begin
                out_load       = 1'b1;
                out_valid_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg  <= out_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_from_skid)
        begin
            out_data_reg <= skid_data_reg;
        end
        else if (out_load)
        begin
            out_data_reg <= last_blk;
        end
        if (skid_load)
        begin
            skid_data_reg <= last_blk;
        end
    end

    assign result.valid      = out_valid_reg;
    assign result.half_a_out = out_data_reg.a;
    assign result.half_b_out = out_data_reg.b;

    // The skid stage only ever holds a block behind a waiting output.
    a_skid_behind_out : assert property (@(posedge clk) disable iff (!rst_n)
        skid_valid_reg |-> out_valid_reg)
        else $error("skid stage holds a block while the output is empty");

    // A block leaving the pipeline into a stalled output must land in the skid stage.
    a_stall_fills_skid : assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !result.ready && stage_valid[NSTAGES] && !skid_valid_reg)
        |=> skid_valid_reg)
        else $error("block leaving the pipeline was dropped during a stall");

    // The skid stage fills only from a stalled output with a block arriving.
    a_skid_fill_cause : assert property (@(posedge clk) disable iff (!rst_n)
        $rose(skid_valid_reg) |->
        $past(out_valid_reg && !result.ready && stage_valid[NSTAGES]))
        else $error("skid stage filled without a stalled output");

    // A full skid stage drains straight into the output on a transfer.
    a_skid_drains : assert property (@(posedge clk) disable iff (!rst_n)
        (skid_valid_reg && result.ready) |=> (out_valid_reg && !skid_valid_reg))
        else $error("skid stage did not drain into the output");

endmodule

FILE: tb/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// TEA block cipher testbench
// Drives 64-bit blocks in both modes through the cipher under a range of key
// and delta settings, with random gaps and stalls on both channels, and checks
// every transformed block against a round-by-round model of the cipher.
// ----------------------------------------------------------------------------
module tb;
    import tea_pkg::*;

    localparam int   TEA_ROUNDS   = 32;
    localparam int   LATENCY      = 2 * TEA_ROUNDS + 1;
    localparam int   HOLDOFF_LEN  = 160;
    localparam logic MODE_ENCRYPT = 1'b0;
    localparam logic MODE_DECRYPT = 1'b1;

    // Shadow of the key and delta registers, with the queue of blocks that the
    // cipher still owes us.
    class tea_scoreboard;
        word_t key_word [4];
        word_t delta;
        blk_t  owed_blocks [$];
        int    failures;
        int    blocks_checked;
        int    encrypts;
        int    decrypts;

        function new();
            key_word = '{default: '0};
            delta    = DELTA_RESET;
        endfunction

        function void set_register(logic [CFG_IDX_W-1:0] idx, word_t data);
            case (idx)
                CFG_KEY_0: key_word[0] = data;
                CFG_KEY_1: key_word[1] = data;
                CFG_KEY_2: key_word[2] = data;
                CFG_KEY_3: key_word[3] = data;
                CFG_DELTA: delta       = data;
                default:   ;
            endcase
        endfunction

        function word_t tea_mix(word_t x, word_t sum, word_t ka, word_t kb);
            return ((x << 4) + ka) ^ (x + sum) ^ ((x >> 5) + kb);
        endfunction

        function blk_t tea_rounds(logic mode, word_t a, word_t b);
            word_t sum;
            blk_t  res;
            if (mode == MODE_ENCRYPT)
            begin
                sum = '0;
                for (int r = 0; r < TEA_ROUNDS; r++)
                begin
                    sum += delta;
                    a   += tea_mix(b, sum, key_word[0], key_word[1]);
                    b   += tea_mix(a, sum, key_word[2], key_word[3]);
                end
            end
            else
            begin
                // The starting sum wraps, so delta times the round count is taken mod 2^32.
                sum = word_t'(delta * word_t'(TEA_ROUNDS));
                for (int r = 0; r < TEA_ROUNDS; r++)
                begin
                    b   -= tea_mix(a, sum, key_word[2], key_word[3]);
                    a   -= tea_mix(b, sum, key_word[0], key_word[1]);
                    sum -= delta;
                end
            end
            res.a = a;
            res.b = b;
            return res;
        endfunction

        function void note_block(logic mode, word_t a, word_t b);
            owed_blocks.push_back(tea_rounds(mode, a, b));
            if (mode == MODE_ENCRYPT)
                encrypts++;
            else
                decrypts++;
        endfunction

        function void check_block(word_t a, word_t b);
            blk_t exp_blk;
            if (owed_blocks.size() == 0)
            begin
                $display("%0t: unexpected result a=%h b=%h", $time, a, b);
                failures++;
                return;
            end
            exp_blk = owed_blocks.pop_front();
            blocks_checked++;
            if (a !== exp_blk.a)
            begin
                $display("%0t: half_a_out expected %h actual %h", $time, exp_blk.a, a);
                failures++;
            end
            if (b !== exp_blk.b)
            begin
                $display("%0t: half_b_out expected %h actual %h", $time, exp_blk.b, b);
                failures++;
            end
        endfunction
    endclass

    logic                 clk;
    logic                 rst_n;
    logic                 cfg_we;
    logic [CFG_IDX_W-1:0] cfg_index;
    word_t                cfg_data;

    tea_block_if  blk_ch ();
    tea_result_if res_ch ();

    tea_scoreboard sb;
    bit            sender_steady;
    bit            receiver_steady;
    int            holdoff_request;
    int            settings_applied;

    tea_block_cipher #(
        .ROUNDS (TEA_ROUNDS)
    ) i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .block     (blk_ch),
        .result    (res_ch),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    initial
    begin
        #4_000_000;
        $display("%0t: run did not finish in time", $time);
        $display("tea_block_cipher verification failed");
        $finish;
    end

    // Both channels are sampled here, inputs first so that an expectation is in
    // place before any result of the same edge is checked.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (blk_ch.valid && blk_ch.ready)
                sb.note_block(blk_ch.mode, blk_ch.half_a_in, blk_ch.half_b_in);
            if (res_ch.valid && res_ch.ready)
                sb.check_block(res_ch.half_a_out, res_ch.half_b_out);
        end
    end

    // Result receiver. A hold-off request is counted down here, in cycles.
    initial
    begin
        int hold_left;
        hold_left    = 0;
        res_ch.ready = 1'b0;
        wait (rst_n === 1'b1);
        forever
        begin
            @(negedge clk);
            if (holdoff_request > 0)
            begin
                hold_left       = holdoff_request;
                holdoff_request = 0;
            end
            if (hold_left > 0)
            begin
                res_ch.ready <= 1'b0;
                hold_left--;
            end
            else if (receiver_steady)
                res_ch.ready <= 1'b1;
            else
                res_ch.ready <= ($urandom_range(0, 99) >= 33);
        end
    end

    function automatic word_t pick_word();
        case ($urandom_range(0, 9))
            0:       return '0;
            1:       return '1;
            2:       return word_t'(1) << $urandom_range(0, WORD_W - 1);
            3:       return ~(word_t'(1) << $urandom_range(0, WORD_W - 1));
            default: return word_t'($urandom);
        endcase
    endfunction

    // Returns at the rising edge of the transfer, with valid still high.
    task automatic send_block(logic mode, word_t a, word_t b);
        while (!sender_steady && $urandom_range(0, 99) < 33)
        begin
            @(negedge clk);
            blk_ch.valid <= 1'b0;
        end
        @(negedge clk);
        blk_ch.valid     <= 1'b1;
        blk_ch.mode      <= mode;
        blk_ch.half_a_in <= a;
        blk_ch.half_b_in <= b;
        @(posedge clk);
        while (!blk_ch.ready)
            @(posedge clk);
    endtask

    task automatic wait_drained();
        @(negedge clk);
        blk_ch.valid <= 1'b0;
        while (sb.owed_blocks.size() != 0)
            @(posedge clk);
        repeat (2) @(posedge clk);
    endtask

    task automatic write_register(logic [CFG_IDX_W-1:0] idx, word_t data);
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
        sb.set_register(idx, data);
        @(negedge clk);
        cfg_we    <= 1'b0;
    endtask

    task automatic apply_setting(word_t k0, word_t k1, word_t k2, word_t k3, word_t d);
        write_register(CFG_KEY_0, k0);
        write_register(CFG_KEY_1, k1);
        write_register(CFG_KEY_2, k2);
        write_register(CFG_KEY_3, k3);
        write_register(CFG_DELTA, d);
        // Writes beyond delta must leave every register alone.
        write_register(CFG_IDX_W'(CFG_DELTA + 1 + $urandom_range(0, 2)), word_t'($urandom));
        settings_applied++;
    endtask

    task automatic directed_blocks();
        word_t p;
        word_t q;
        blk_t  ct;
        send_block(MODE_ENCRYPT, '0, '0);
        send_block(MODE_DECRYPT, '0, '0);
        send_block(MODE_ENCRYPT, '1, '1);
        send_block(MODE_DECRYPT, '1, '1);
        send_block(MODE_ENCRYPT, 32'h8000_0000, 32'h0000_0001);
        send_block(MODE_DECRYPT, 32'h0000_0001, 32'h8000_0000);
        send_block(MODE_ENCRYPT, 32'hAAAA_AAAA, 32'h5555_5555);
        // A round trip: the decrypted ciphertext should come back as the plaintext.
        p  = word_t'($urandom);
        q  = word_t'($urandom);
        ct = sb.tea_rounds(MODE_ENCRYPT, p, q);
        send_block(MODE_ENCRYPT, p, q);
        send_block(MODE_DECRYPT, ct.a, ct.b);
    endtask

    task automatic random_blocks(int count);
        word_t p;
        word_t q;
        blk_t  ct;
        for (int n = 0; n < count; n++)
        begin
            p = pick_word();
            q = pick_word();
            case ($urandom_range(0, 3))
                0: send_block(MODE_ENCRYPT, p, q);
                1: send_block(MODE_DECRYPT, p, q);
                2:
                begin
                    ct = sb.tea_rounds(MODE_ENCRYPT, p, q);
                    send_block(MODE_DECRYPT, ct.a, ct.b);
                end
                default:
                begin
                    ct = sb.tea_rounds(MODE_ENCRYPT, p, q);
                    send_block(MODE_ENCRYPT, p, q);
                    send_block(MODE_DECRYPT, ct.a, ct.b);
                end
            endcase
        end
    endtask

    function automatic word_t rand_word();
        return word_t'($urandom);
    endfunction

    initial
    begin
        sb               = new();
        sender_steady    = 1'b0;
        receiver_steady  = 1'b0;
        holdoff_request  = 0;
        settings_applied = 0;
        rst_n            = 1'b0;
        cfg_we           = 1'b0;
        cfg_index        = '0;
        cfg_data         = '0;
        blk_ch.valid     = 1'b0;
        blk_ch.mode      = MODE_ENCRYPT;
        blk_ch.half_a_in = '0;
        blk_ch.half_b_in = '0;
        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        repeat (2) @(posedge clk);

        // Reset values first, after writes that fall outside the register map.
        write_register(CFG_IDX_W'(CFG_DELTA + 1), '1);
        write_register(CFG_IDX_W'(CFG_DELTA + 3), word_t'($urandom));
        directed_blocks();
        random_blocks(80);
        wait_drained();

        apply_setting('0, '0, '0, '0, '0);
        directed_blocks();
        random_blocks(60);
        wait_drained();

        apply_setting('1, '1, '1, '1, '1);
        directed_blocks();
        random_blocks(60);
        wait_drained();

        // Receiver holds off while blocks keep coming, so the pipeline backs up.
        apply_setting(rand_word(), rand_word(), rand_word(), rand_word(), DELTA_RESET);
        sender_steady   = 1'b1;
        holdoff_request = HOLDOFF_LEN;
        random_blocks(110);
        sender_steady   = 1'b0;
        random_blocks(60);
        wait_drained();

        // A long stretch with no gaps on either side.
        apply_setting(rand_word(), rand_word(), rand_word(), rand_word(), rand_word());
        sender_steady   = 1'b1;
        receiver_steady = 1'b1;
        random_blocks(120);
        sender_steady   = 1'b0;
        receiver_steady = 1'b0;
        random_blocks(40);
        wait_drained();

        // The sender pauses halfway until the pipeline is empty.
        apply_setting(rand_word(), rand_word(), rand_word(), rand_word(), DELTA_RESET);
        random_blocks(80);
        wait_drained();
        random_blocks(80);
        wait_drained();

        apply_setting(rand_word(), rand_word(), rand_word(), rand_word(), rand_word());
        random_blocks(120);
        wait_drained();

        repeat (LATENCY + 8) @(posedge clk);
        if (sb.owed_blocks.size() != 0)
        begin
            $display("%0t: %0d transformed blocks never arrived", $time, sb.owed_blocks.size());
            sb.failures++;
        end
        $display("Checked %0d blocks (%0d encryptions, %0d decryptions) under %0d key/delta",
                 sb.blocks_checked, sb.encrypts, sb.decrypts, settings_applied + 1);
        $display("settings, including all-zero and all-one registers and a full back-up.");
        if (sb.failures == 0)
            $display("tea_block_cipher verification clean");
        else
            $display("tea_block_cipher verification failed");
        $finish;
    end
endmodule

FILE: files.f
rtl/tea_pkg.sv
rtl/tea_if.sv
rtl/tea_half_round.sv
rtl/tea_block_cipher.sv
tb/tb.sv
